@@ rtl/terminal_output_escape_filter_core_assert.svh @@
// Assertion macros for the checker file of the escape filter.
// Depends on nothing; included by bare file name.
`ifndef TERMINAL_OUTPUT_ESCAPE_FILTER_CORE_ASSERT_SVH
`define TERMINAL_OUTPUT_ESCAPE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while the disable term is true
`define TOFILT_ASSERT_IMPLY(label, clk, dis, a, c) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
        else $error("tofilt assertion failed");

// Next-cycle implication, ignored while the disable term is true
`define TOFILT_ASSERT_NEXT(label, clk, dis, a, c) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
        else $error("tofilt assertion failed");

`endif

@@ rtl/tofilt_pkg.sv @@
// Shared types and constants of the terminal output escape filter.
// No dependencies; imported by every module of the block.
package tofilt_pkg;

    // Default line store depth
    localparam int BUF_SIZE_DEF = 64;

    // Byte codes the filter reacts to
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_CSI    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAB,
        ST_RD,
        ST_LD
    } t_state;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       chunk_last;
    } t_out_word;

    // Decision for one written byte
    typedef struct packed {
        t_phase next_phase;
        logic   keep;
        logic   is_tab;
        logic   is_eol;
    } t_class;

endpackage

@@ rtl/tofilt_class.sv @@
// Byte classifier: escape sequence tracking and control byte filtering.
// Depends on tofilt_pkg.
module tofilt_class (
    input  logic [7:0]            i_char,
    input  tofilt_pkg::t_phase    i_phase,
    output tofilt_pkg::t_class    o_class
);
    import tofilt_pkg::*;

    logic is_letter;
    logic is_ctrl;

    // Classify the byte
    always_comb begin
        is_letter = i_char inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_ctrl   = ((i_char < CH_SPACE) && (i_char != CH_CR) && (i_char != CH_LF)
                     && (i_char != CH_TAB)) || (i_char == CH_DEL);

        o_class.next_phase = i_phase;
        o_class.keep       = 1'b0;
        o_class.is_tab     = 1'b0;
        o_class.is_eol     = (i_char == CH_CR) || (i_char == CH_LF);

        if (i_char == CH_ESC) begin
            o_class.next_phase = PH_ESC;
        end else begin
            case (i_phase)
                PH_ESC: begin
                    o_class.next_phase = (i_char == CH_LBRK) ? PH_CSI : PH_NORMAL;
                end
                PH_CSI: begin
                    if (is_letter) begin
                        o_class.next_phase = PH_NORMAL;
                    end
                end
                default: begin
                    // normal phase: pass printable, widen tab, drop control
                    o_class.next_phase = PH_NORMAL;
                    o_class.is_tab     = (i_char == CH_TAB);
                    o_class.keep       = !is_ctrl && (i_char != CH_TAB);
                end
            endcase
        end
    end

endmodule

@@ rtl/terminal_output_escape_filter_core.sv @@
// Terminal output escape filter: top level with line store and read-out sequencer.
// Depends on tofilt_pkg and tofilt_class.
//
// Usage:
//   Input channel (i_in_valid / i_in_word / o_in_stall) carries one word per
//   operation: write one character or flush the pending line. Output channel
//   (o_out_valid / o_out_word / i_out_stall) carries the chunk bytes, the
//   final one marked by chunk_last. i_cfg_we / i_cfg_data set r_link;
//   while it is 0, accepted words change nothing.
//   A TAB is expanded into four writes of a space into the line store port,
//   one per cycle, as room allows. A read-out handles each byte as a memory
//   read, then an output register load, and reads the next byte only once the
//   output slot is free; o_in_stall stays high for the whole read-out
//   and for the TAB sequence, so store reads and writes never overlap.
//   The output register holds its word while i_out_stall is high, and the
//   next memory read waits for the slot; a finished last byte may still wait
//   in the output register while new input words are taken.
//   Synchronous reset clears the link flag, escape phase, fill count and the
//   output valid; the store itself is not cleared since only written entries
//   are ever read.
module terminal_output_escape_filter_core #(
    parameter int BUF_SIZE = tofilt_pkg::BUF_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    input  logic                   i_in_valid,
    input  tofilt_pkg::t_in_word   i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output tofilt_pkg::t_out_word  o_out_word,
    input  logic                   i_out_stall
);
    import tofilt_pkg::*;

    localparam int AW = $clog2(BUF_SIZE);
    localparam int CW = $clog2(BUF_SIZE + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BUF_SIZE);
    localparam logic [CW-1:0] HIGH_CNT = CW'(BUF_SIZE - 1);

    // Line store
    logic [7:0]    mem [BUF_SIZE];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    // Control state
    t_state        r_state,   n_state;
    t_phase        r_phase,   n_phase;
    logic [CW-1:0] r_fill,    n_fill;
    logic [CW-1:0] r_len,     n_len;
    logic [AW-1:0] r_rd_idx,  n_rd_idx;
    logic [1:0]    r_tab_cnt, n_tab_cnt;
    logic          r_link;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out_word;

    t_class        cls;
    logic          accept;
    logic          room;
    logic          out_load;
    logic          out_last;
    logic [CW-1:0] fill_after;

    tofilt_class u_class (
        .i_char  (i_in_word.char_in),
        .i_phase (r_phase),
        .o_class (cls)
    );

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign room        = (r_fill < FULL_CNT);
    assign out_last    = (CW'(r_rd_idx) == (r_len - CW'(1)));

    // Next state, store access and read-out control
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_len       = r_len;
        n_rd_idx    = r_rd_idx;
        n_tab_cnt   = r_tab_cnt;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_fill[AW-1:0];
        mem_wdata   = i_in_word.char_in;
        out_load    = 1'b0;
        fill_after  = room ? (r_fill + CW'(1)) : r_fill;

        case (r_state)
            ST_IDLE: begin
                if (accept && r_link) begin
                    if (i_in_word.op == OP_FLUSH) begin
                        if (r_fill != '0) begin
                            n_len    = r_fill;
                            n_fill   = '0;
                            n_rd_idx = '0;
                            n_state  = ST_RD;
                        end
                    end else begin
                        n_phase = cls.next_phase;
                        if (cls.is_tab) begin
                            n_tab_cnt = 2'd3;
                            n_state   = ST_TAB;
                        end else if (cls.keep) begin
                            mem_we = room;
                            n_fill = fill_after;
                            // end of line or nearly full store: start read-out
                            if ((fill_after >= HIGH_CNT) || cls.is_eol) begin
                                n_len    = fill_after;
                                n_fill   = '0;
                                n_rd_idx = '0;
                                n_state  = ST_RD;
                            end
                        end
                    end
                end
            end
            ST_TAB: begin
                // append one space a cycle, as room allows
                mem_wdata = CH_SPACE;
                mem_we    = room;
                n_fill    = fill_after;
                n_tab_cnt = r_tab_cnt - 2'd1;
                if (r_tab_cnt == 2'd0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                // read only once the output slot is free at this edge
                if (!r_out_valid || !i_out_stall) begin
                    mem_re  = 1'b1;
                    n_state = ST_LD;
                end
            end
            ST_LD: begin
                out_load = 1'b1;
                if (out_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                    n_state  = ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output slot: drop on take, fill on load
        n_out_valid = r_out_valid && i_out_stall;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.out_byte   <= r_rd_data;
            r_out_word.chunk_last <= out_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_NORMAL;
            r_fill      <= '0;
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_tab_cnt   <= '0;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_rd_idx    <= n_rd_idx;
            r_tab_cnt   <= n_tab_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_link <= i_cfg_data;
            end
        end
    end

endmodule

@@ rtl/tofilt_checker.sv @@
// Port-level checker for the escape filter, bound to the top level.
// Depends on tofilt_pkg and terminal_output_escape_filter_core_assert.svh.
`include "terminal_output_escape_filter_core_assert.svh"

module tofilt_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input tofilt_pkg::t_out_word  o_out_word,
    input logic                   i_out_stall
);
    import tofilt_pkg::*;

    // reset leaves both channels quiet and ready for input
    `TOFILT_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_stall)

    // stalled word holds
    `TOFILT_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_word))

    // input waits while a chunk is still being read out
    `TOFILT_ASSERT_IMPLY(a_mid_chunk_stall, i_clk, !i_rst_n,
        o_out_valid && !o_out_word.chunk_last, o_in_stall)

    // after a non-final word is taken, more of the chunk follows
    `TOFILT_ASSERT_NEXT(a_chunk_continues, i_clk, !i_rst_n,
        o_out_valid && !o_out_word.chunk_last && !i_out_stall, o_in_stall)

endmodule

bind terminal_output_escape_filter_core tofilt_checker u_tofilt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
